// ----- rtl/cbm_pkg.sv -----
// Shared constants and types for the cartridge bank mapper, including the register windows.
package cbm_pkg;

    localparam int ROM_BANK_BITS = 7;
    localparam int RAM_BANK_BITS = 2;

    // Bank registers are kept at full width; masks drop bits beyond the fitted size
    localparam int ROM_BANK_W = 7;
    localparam int RAM_BANK_W = 2;
    localparam int ADDR_W     = 16;
    localparam int PHYS_W     = 21;

    localparam logic [ROM_BANK_W-1:0] ROM_BANK_MASK =
        ROM_BANK_W'((1 << ROM_BANK_BITS) - 1);
    localparam logic [RAM_BANK_W-1:0] RAM_BANK_MASK =
        RAM_BANK_W'((1 << RAM_BANK_BITS) - 1);
    localparam logic [1:0] UPPER_MASK = 2'((1 << (ROM_BANK_BITS - 5)) - 1);

    localparam logic [4:0] LOW_FIELD_MASK = 5'h1f;
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = ROM_BANK_W'(1);

    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_RAM  = 2'd1,
        TGT_NONE = 2'd2
    } t_target;

    // Controller register window, address bits 14:13 within the ROM range
    typedef enum logic [1:0] {
        WIN_RAM_ENABLE = 2'd0,
        WIN_ROM_LOW    = 2'd1,
        WIN_UPPER      = 2'd2,
        WIN_MODE       = 2'd3
    } t_window;

endpackage

// ----- rtl/cartridge_bank_mapper.sv -----
// Cartridge bank mapper: one-stage bus address translation with bank controller state.
// Transfers pass through the input register, one decode stage and the result register.
// Throughput: one access per cycle while the result is not stalled; the decode stage sets
// this, and bank state updates as each access moves into the result register.
// Reset (synchronous, active low): bank controller absent, ROM bank 1, RAM bank 0,
// banking mode 0, RAM disabled, both pipeline registers empty.
module cartridge_bank_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_target,
    output logic [20:0] o_physical_address,
    output logic        o_rom_wr_fault,
    output logic        o_ram_enabled
);

    logic                               r_ctrl_present;
    logic [cbm_pkg::ROM_BANK_W-1:0]     r_rom_bank, n_rom_bank;
    logic [cbm_pkg::RAM_BANK_W-1:0]     r_ram_bank, n_ram_bank;
    logic                               r_banking_mode, n_banking_mode;
    logic                               r_ram_enable, n_ram_enable;

    logic                               r_in_valid;
    logic                               r_req_type;
    logic [cbm_pkg::ADDR_W-1:0]         r_addr;
    logic [7:0]                         r_data;

    logic                               r_out_valid;
    cbm_pkg::t_target                   r_target, n_target;
    logic [cbm_pkg::PHYS_W-1:0]         r_phys, n_phys;
    logic                               r_err, n_err;
    logic                               r_ram_en_out;

    logic out_load;
    logic in_load;
    logic advance;
    logic rom_range;
    logic ram_range;
    logic [4:0] low_field;
    cbm_pkg::t_window window;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = !in_load;

    assign rom_range = !r_addr[15];
    assign ram_range = (r_addr[15:13] == 3'b101);
    assign window    = cbm_pkg::t_window'(r_addr[14:13]);
    assign low_field = (r_data[4:0] == 5'd0) ? 5'd1 : r_data[4:0];

    always_comb begin
        n_rom_bank     = r_rom_bank;
        n_ram_bank     = r_ram_bank;
        n_banking_mode = r_banking_mode;
        n_ram_enable   = r_ram_enable;
        n_target       = cbm_pkg::TGT_NONE;
        n_phys         = '0;
        n_err          = 1'b0;

        if (rom_range) begin
            if (r_req_type) begin
                if (r_ctrl_present) begin
                    unique case (window)
                        cbm_pkg::WIN_RAM_ENABLE: begin
                            n_ram_enable = (r_data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
                        end
                        cbm_pkg::WIN_ROM_LOW: begin
                            n_rom_bank = {r_rom_bank[6:5], low_field} & cbm_pkg::ROM_BANK_MASK;
                        end
                        cbm_pkg::WIN_UPPER: begin
                            if (!r_banking_mode) begin
                                n_rom_bank = {r_data[1:0] & cbm_pkg::UPPER_MASK,
                                              r_rom_bank[4:0]} & cbm_pkg::ROM_BANK_MASK;
                            end else begin
                                n_ram_bank = r_data[1:0] & cbm_pkg::RAM_BANK_MASK;
                            end
                        end
                        cbm_pkg::WIN_MODE: begin
                            n_banking_mode = r_data[0];
                            if (!r_data[0]) begin
                                n_ram_bank = '0;
                            end
                        end
                        default: begin
                            n_ram_enable = r_ram_enable;
                        end
                    endcase
                end else begin
                    n_err = 1'b1;
                end
            end else if (!r_addr[14]) begin
                n_target = cbm_pkg::TGT_ROM;
                n_phys   = {7'd0, r_addr[13:0]};
            end else begin
                n_target = cbm_pkg::TGT_ROM;
                n_phys   = {r_rom_bank & cbm_pkg::ROM_BANK_MASK, r_addr[13:0]};
            end
        end else if (ram_range) begin
            n_target = cbm_pkg::TGT_RAM;
            n_phys   = {6'd0, r_ram_bank & cbm_pkg::RAM_BANK_MASK, r_addr[12:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_present <= 1'b0;
            r_rom_bank     <= cbm_pkg::ROM_BANK_RESET;
            r_ram_bank     <= '0;
            r_banking_mode <= 1'b0;
            r_ram_enable   <= 1'b0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ctrl_present <= i_cfg_data;
            end
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_rom_bank     <= n_rom_bank;
                r_ram_bank     <= n_ram_bank;
                r_banking_mode <= n_banking_mode;
                r_ram_enable   <= n_ram_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_req_type <= i_req_type;
            r_addr     <= i_bus_address;
            r_data     <= i_write_byte;
        end
        if (advance) begin
            r_target     <= n_target;
            r_phys       <= n_phys;
            r_err        <= n_err;
            r_ram_en_out <= n_ram_enable;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_target           = r_target;
    assign o_physical_address = r_phys;
    assign o_rom_wr_fault     = r_err;
    assign o_ram_enabled      = r_ram_en_out;

    // An error result is never a memory access
    a_err_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_err) |-> (r_target == cbm_pkg::TGT_NONE))
        else $error("write error result carries a memory target");

    a_none_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_target == cbm_pkg::TGT_NONE) |-> (r_phys == '0))
        else $error("non-access result with non-zero address");

    // Low ROM bank field is never zero
    a_rom_low_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rom_bank[4:0] != 5'd0))
        else $error("ROM bank low field became zero");

    a_mode0_ram_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_banking_mode |-> (r_ram_bank == '0))
        else $error("RAM bank set while in mode 0");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule

// ----- dv/cartridge_bank_mapper_test.sv -----
// Self-checking testbench for the cartridge bank mapper: directed and random bus accesses.
`timescale 1ns / 100ps

module cartridge_bank_mapper_test;

    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        cbm_pkg::t_target target;
        logic [20:0]      phys;
        logic             werr;
        logic             ram_en;
    } t_access_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = 1'b0;
    logic [15:0] i_bus_address = '0;
    logic [7:0]  i_write_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_target;
    logic [20:0] o_physical_address;
    logic        o_rom_wr_fault;
    logic        o_ram_enabled;

    // mirror of the mapper's bank state
    logic                           mdl_present = 1'b0;
    logic [cbm_pkg::ROM_BANK_W-1:0] mdl_rom_bank = cbm_pkg::ROM_BANK_RESET;
    logic [cbm_pkg::RAM_BANK_W-1:0] mdl_ram_bank = '0;
    logic                           mdl_mode = 1'b0;
    logic                           mdl_ram_en = 1'b0;

    t_access_result pending_results[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_done = 0;
    int hold_cnt = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_fail = 0;

    cartridge_bank_mapper dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_req_type         (i_req_type),
        .i_bus_address      (i_bus_address),
        .i_write_byte       (i_write_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_target           (o_target),
        .o_physical_address (o_physical_address),
        .o_rom_wr_fault     (o_rom_wr_fault),
        .o_ram_enabled      (o_ram_enabled)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_access_result map_access(logic rw, logic [15:0] addr,
                                                  logic [7:0] data);
        t_access_result r;
        logic [4:0] low;
        logic [1:0] up;
        r.target = cbm_pkg::TGT_NONE;
        r.phys   = '0;
        r.werr   = 1'b0;
        if (addr <= 16'h7fff) begin
            if (rw) begin
                if (!mdl_present) begin
                    r.werr = 1'b1;
                end else begin
                    case (cbm_pkg::t_window'(addr[14:13]))
                        cbm_pkg::WIN_RAM_ENABLE: begin
                            mdl_ram_en = (data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
                        end
                        cbm_pkg::WIN_ROM_LOW: begin
                            low = data[4:0] & cbm_pkg::LOW_FIELD_MASK;
                            if (low == 5'd0)
                                low = 5'd1;
                            mdl_rom_bank =
                                ((mdl_rom_bank
                                  & ~cbm_pkg::ROM_BANK_W'(cbm_pkg::LOW_FIELD_MASK))
                                 | cbm_pkg::ROM_BANK_W'(low)) & cbm_pkg::ROM_BANK_MASK;
                        end
                        cbm_pkg::WIN_UPPER: begin
                            if (!mdl_mode) begin
                                up = data[1:0] & cbm_pkg::UPPER_MASK;
                                mdl_rom_bank =
                                    ((mdl_rom_bank
                                      & cbm_pkg::ROM_BANK_W'(cbm_pkg::LOW_FIELD_MASK))
                                     | (cbm_pkg::ROM_BANK_W'(up) << 5))
                                    & cbm_pkg::ROM_BANK_MASK;
                            end else begin
                                mdl_ram_bank = data[1:0] & cbm_pkg::RAM_BANK_MASK;
                            end
                        end
                        cbm_pkg::WIN_MODE: begin
                            mdl_mode = data[0];
                            if (!data[0])
                                mdl_ram_bank = '0;
                        end
                    endcase
                end
            end else if (addr <= 16'h3fff) begin
                r.target = cbm_pkg::TGT_ROM;
                r.phys   = 21'(addr);
            end else begin
                r.target = cbm_pkg::TGT_ROM;
                r.phys   = 21'({mdl_rom_bank & cbm_pkg::ROM_BANK_MASK, addr[13:0]});
            end
        end else if (addr >= 16'ha000 && addr <= 16'hbfff) begin
            r.target = cbm_pkg::TGT_RAM;
            r.phys   = 21'({mdl_ram_bank & cbm_pkg::RAM_BANK_MASK, addr[12:0]});
        end
        r.ram_en = mdl_ram_en;
        return r;
    endfunction

    // Called just after a rising edge; leaves valid high after the transfer so the
    // next call can keep the stream going without a bubble.
    task automatic send_access(input logic rw, input logic [15:0] addr,
                               input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= rw;
        i_bus_address <= addr;
        i_write_byte  <= data;
        do
            @(posedge i_clk);
        while (o_in_stall);
        pending_results.push_back(map_access(rw, addr, data));
        n_sent++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_controller_present(input logic v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mdl_present = v;
    endtask

    // Receiver side: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != hold_done) begin
            hold_done   <= hold_req;
            hold_cnt    <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result target %0d addr %h", $time,
                         o_target, o_physical_address);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_target !== want.target) begin
                    $display("%0t: target exp %0d got %0d", $time, want.target, o_target);
                    n_fail++;
                end
                if (o_physical_address !== want.phys) begin
                    $display("%0t: physical_address exp %h got %h", $time, want.phys,
                             o_physical_address);
                    n_fail++;
                end
                if (o_rom_wr_fault !== want.werr) begin
                    $display("%0t: rom_wr_fault exp %0b got %0b", $time, want.werr,
                             o_rom_wr_fault);
                    n_fail++;
                end
                if (o_ram_enabled !== want.ram_en) begin
                    $display("%0t: ram_enabled exp %0b got %0b", $time, want.ram_en,
                             o_ram_enabled);
                    n_fail++;
                end
            end
        end
    end

    // Controller absent: every ROM-range write is an error, reads map as usual
    task automatic test_no_controller;
        write_controller_present(1'b0);
        send_access(1'b0, 16'h0000, 8'h00);
        send_access(1'b0, 16'h3fff, 8'hff);
        send_access(1'b0, 16'h4000, 8'h00);
        send_access(1'b0, 16'h7fff, 8'h00);
        send_access(1'b0, 16'ha000, 8'h00);
        send_access(1'b1, 16'hbfff, 8'hff);
        send_access(1'b0, 16'h8000, 8'h00);
        send_access(1'b0, 16'hffff, 8'h00);
        send_access(1'b1, 16'hc000, 8'h55);
        send_access(1'b1, 16'h0000, 8'h0a);
        send_access(1'b1, 16'h2000, 8'h00);
        send_access(1'b1, 16'h6000, 8'h01);
    endtask

    task automatic test_controller_writes;
        write_controller_present(1'b1);
        send_access(1'b1, 16'h0000, 8'h0a);
        send_access(1'b0, 16'h4000, 8'h00);
        send_access(1'b1, 16'h2000, 8'h00);   // zero low field reads as bank 1
        send_access(1'b0, 16'h4001, 8'h00);
        send_access(1'b1, 16'h3fff, 8'hff);
        send_access(1'b1, 16'h4000, 8'hff);
        send_access(1'b0, 16'h7fff, 8'h00);
        send_access(1'b1, 16'h6000, 8'h01);
        send_access(1'b1, 16'h5fff, 8'h03);
        send_access(1'b0, 16'hbfff, 8'h00);
        send_access(1'b1, 16'h7fff, 8'hfe);   // back to mode 0 clears the RAM bank
        send_access(1'b0, 16'ha000, 8'h00);
        send_access(1'b1, 16'h1fff, 8'h1b);
        send_access(1'b1, 16'h0000, 8'hfa);
    endtask

    // Receiver holds off long enough for the pipeline to back up into the input
    task automatic test_backpressure;
        int k;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req++;
        for (k = 0; k < 40; k++)
            send_access(1'(k), 16'($urandom), 8'($urandom));
    endtask

    task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct);
        int k;
        int sel;
        logic rw;
        logic [15:0] addr;
        logic [7:0] data;
        send_idle_pct = snd_pct;
        stall_pct = rcv_pct;
        for (k = 0; k < n; k++) begin
            sel  = $urandom_range(0, 99);
            rw   = 1'($urandom);
            addr = 16'($urandom);
            data = 8'($urandom);
            if (sel < 35) begin
                rw   = 1'b1;
                addr = 16'($urandom_range(0, 16'h7fff));
                case (cbm_pkg::t_window'(addr[14:13]))
                    cbm_pkg::WIN_RAM_ENABLE:
                        if ($urandom_range(0, 1)) data[3:0] = cbm_pkg::RAM_ENABLE_KEY;
                    cbm_pkg::WIN_ROM_LOW:
                        if ($urandom_range(0, 7) == 0) data[4:0] = 5'd0;
                    default: ;
                endcase
            end else if (sel < 60) begin
                rw   = 1'b0;
                addr = 16'($urandom_range(16'h4000, 16'h7fff));
            end else if (sel < 82) begin
                addr = 16'($urandom_range(16'ha000, 16'hbfff));
            end else if (sel < 90) begin
                rw   = 1'b0;
                addr = 16'($urandom_range(0, 16'h3fff));
            end
            send_access(rw, addr, data);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_controller();
        test_controller_writes();
        test_backpressure();
        test_random_traffic(240, 0, 0);
        test_random_traffic(250, 75, 0);
        write_controller_present(1'b0);
        test_random_traffic(150, 0, 75);
        write_controller_present(1'b1);
        test_random_traffic(100, 0, 75);
        test_random_traffic(250, 13, 13);

        send_idle_pct = 0;
        stall_pct = 0;
        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d accesses (%0d results checked): ROM, RAM and unmapped ranges,",
                 n_sent, n_checked);
        $display("all controller windows, controller absent and present, stalls both ways.");
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- cartridge_bank_mapper.f -----
rtl/cbm_pkg.sv
rtl/cartridge_bank_mapper.sv
dv/cartridge_bank_mapper_test.sv
